@@ src/tks_pkg.sv @@
// Shared types and constants for the top-k score selector.
// No dependencies; every other file refers to it by scoped names.
package tks_pkg;

	localparam int DATA_W       = 32;
	localparam int KEEP_W       = 5;
	localparam int MAX_KEEP_DEF = 16;

	localparam logic [KEEP_W-1:0] KEEP_RST = 5'd16;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	// one list entry as held by a cell
	typedef struct packed {
		logic              vld;
		logic [DATA_W-1:0] eref;
		logic [DATA_W-1:0] escore;
	} entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic ins_acc;  // insert item accepted this cycle
		logic ins_go;   // accepted and not a duplicate
		logic shift;    // drain: move the list up by one
	} cell_ctl_t;

endpackage

@@ src/tks_ifs.sv @@
// Handshake channels of the top-k score selector: items, results, config.
// Depends on tks_pkg for field widths.
interface tks_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [tks_pkg::DATA_W-1:0] item_ref;
	logic [tks_pkg::DATA_W-1:0] item_score;

	modport source (output valid, op, item_ref, item_score, input ready);
	modport sink (input valid, op, item_ref, item_score, output ready);
endinterface

interface tks_out_if;
	logic                       valid;
	logic                       ready;
	logic [tks_pkg::DATA_W-1:0] out_ref;
	logic [tks_pkg::DATA_W-1:0] out_score;
	logic                       out_valid;
	logic                       out_last;

	modport source (output valid, out_ref, out_score, out_valid, out_last, input ready);
	modport sink (input valid, out_ref, out_score, out_valid, out_last, output ready);
endinterface

interface tks_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [tks_pkg::KEEP_W-1:0] keep_count;

	modport source (output valid, keep_count, input ready);
	modport sink (input valid, keep_count, output ready);
endinterface

@@ src/tks_cell.sv @@
// One slot of the sorted list: compare against the candidate, take from
// the upper neighbor on insert, from the lower neighbor on drain. Uses tks_pkg.
module tks_cell (
	input  logic                       clk,
	input  logic                       arst_n,
	input  tks_pkg::cell_ctl_t         ctl,
	input  logic                       rng,
	input  logic [tks_pkg::DATA_W-1:0] item_ref,
	input  logic [tks_pkg::DATA_W-1:0] item_score,
	input  logic                       cand_prev,
	input  tks_pkg::entry_t            prev,
	input  tks_pkg::entry_t            nxt,
	output tks_pkg::entry_t            ent,
	output logic                       cand,
	output logic                       match
);

	logic                       vld_q;
	logic [tks_pkg::DATA_W-1:0] ref_q;
	logic [tks_pkg::DATA_W-1:0] score_q;

	assign ent.vld    = vld_q;
	assign ent.eref   = ref_q;
	assign ent.escore = score_q;

	// insertion point: first in-range slot that is empty or scores lower
	assign cand  = rng && (!vld_q || (score_q < item_score));
	assign match = rng && vld_q && (ref_q == item_ref);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.shift) begin
			vld_q <= nxt.vld;
		end else if (ctl.ins_acc) begin
			if (!rng) begin
				vld_q <= 1'b0;
			end else if (ctl.ins_go && cand) begin
				vld_q <= cand_prev ? prev.vld : 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			ref_q   <= nxt.eref;
			score_q <= nxt.escore;
		end else if (ctl.ins_go && cand) begin
			ref_q   <= cand_prev ? prev.eref : item_ref;
			score_q <= cand_prev ? prev.escore : item_score;
		end
	end

endmodule

@@ src/top_k_score_selector.sv @@
// Top level of the top-k score selector: control, config and the cell row.
// Depends on tks_pkg, tks_ifs (channels) and tks_cell.
//
// Usage:
//   items   : op=insert adds (item_ref, item_score) to a best-first list of
//             at most keep_count entries; op=drain emits the list and clears it.
//   results : one item per drained entry, best first, out_last on the final
//             one; an empty list yields a single item with out_valid=0.
//   cfg     : keep_count write, always ready; write only while idle.
// Throughput: inserts go back to back, each done on its accepting edge;
//   every cell compares with the candidate in parallel and the row shifts
//   in the same edge. A drain holds items.ready low for max(n,1) result
//   transfers (one per cycle without stall), the row shifting up one slot
//   per emitted entry.
// Drain start: an accepted drain item puts the control in its drain state;
//   the first result then goes into the registered output slot once free.
// Reset: the list empties and keep_count returns to 16.
// Stall: while results.ready is low a full output slot holds and the row
//   stays put; inserts are still taken after a drain finishes loading.
module top_k_score_selector #(
	parameter int MAX_KEEP = tks_pkg::MAX_KEEP_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tks_in_if.sink     items,
	tks_out_if.source  results,
	tks_cfg_if.sink    cfg
);

	localparam int LIM_W = $clog2(MAX_KEEP + 1);
	localparam int CW    = (LIM_W > tks_pkg::KEEP_W) ? LIM_W : tks_pkg::KEEP_W;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_DRAIN = 1'b1;

	logic                        state_q;
	logic [tks_pkg::KEEP_W-1:0]  keep_q;
	logic [CW-1:0]               keep_ext;
	logic [CW-1:0]               lim;

	tks_pkg::cell_ctl_t          ctl;
	tks_pkg::entry_t             ents [MAX_KEEP];
	tks_pkg::entry_t             nxts [MAX_KEEP];
	tks_pkg::entry_t             prevs [MAX_KEEP];
	logic [MAX_KEEP-1:0]         cands;
	logic [MAX_KEEP-1:0]         cand_prevs;
	logic [MAX_KEEP-1:0]         dup_hits;
	logic [MAX_KEEP-1:0]         rngs;
	logic [MAX_KEEP-1:0]         vlds;

	logic                        in_acc;
	logic                        load;
	logic                        head_last;

	logic                        ov_q;
	logic [tks_pkg::DATA_W-1:0]  oref_q;
	logic [tks_pkg::DATA_W-1:0]  oscore_q;
	logic                        oval_q;
	logic                        olast_q;

	// config register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= tks_pkg::KEEP_RST;
		end else if (cfg.valid) begin
			keep_q <= cfg.keep_count;
		end
	end

	// effective limit: zero reads as one, clamp at the row length
	assign keep_ext = CW'(keep_q);
	always_comb begin
		if (keep_q == '0) begin
			lim = CW'(1);
		end else if (keep_ext > CW'(MAX_KEEP)) begin
			lim = CW'(MAX_KEEP);
		end else begin
			lim = keep_ext;
		end
	end

	// item channel
	assign items.ready = (state_q == ST_IDLE);
	assign in_acc      = items.valid && items.ready;

	// drain: load the output slot whenever it is free
	assign load      = (state_q == ST_DRAIN) && (!ov_q || results.ready);
	assign head_last = !ents[0].vld || (MAX_KEEP == 1) || !vlds[MAX_KEEP > 1 ? 1 : 0];

	assign ctl.ins_acc = in_acc && (items.op == tks_pkg::OP_INSERT);
	assign ctl.ins_go  = ctl.ins_acc && !(|dup_hits);
	assign ctl.shift   = load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (items.op == tks_pkg::OP_DRAIN)) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (load && head_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// cell row; neighbors wired by index, ends tied off
	for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
		assign rngs[i] = (CW'(i) < lim);
		assign vlds[i] = ents[i].vld;

		if (i == 0) begin : g_head
			assign cand_prevs[i] = 1'b0;
			assign prevs[i]      = '0;
		end else begin : g_body
			assign cand_prevs[i] = cands[i-1];
			assign prevs[i]      = ents[i-1];
		end

		if (i == MAX_KEEP - 1) begin : g_tail
			assign nxts[i] = '0;
		end else begin : g_mid
			assign nxts[i] = ents[i+1];
		end

		tks_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.rng        (rngs[i]),
			.item_ref   (items.item_ref),
			.item_score (items.item_score),
			.cand_prev  (cand_prevs[i]),
			.prev       (prevs[i]),
			.nxt        (nxts[i]),
			.ent        (ents[i]),
			.cand       (cands[i]),
			.match      (dup_hits[i])
		);
	end

	// output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (results.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oref_q   <= ents[0].vld ? ents[0].eref : '0;
			oscore_q <= ents[0].vld ? ents[0].escore : '0;
			oval_q   <= ents[0].vld;
			olast_q  <= head_last;
		end
	end

	assign results.valid     = ov_q;
	assign results.out_ref   = oref_q;
	assign results.out_score = oscore_q;
	assign results.out_valid = oval_q;
	assign results.out_last  = olast_q;

`ifndef ASSERT_OFF
	// the list stays packed toward the head
	for (genvar k = 1; k < MAX_KEEP; k++) begin : g_chk
		a_packed: assert property (@(posedge clk) disable iff (!arst_n)
			!vlds[k-1] |-> !vlds[k])
			else $error("list has a hole at slot %0d", k);
	end

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && head_last) |=> (state_q == ST_IDLE) && results.out_last)
		else $error("drain did not end on its last item");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && !results.out_valid) |-> results.out_last)
		else $error("empty-list item without last flag");

	a_no_ins_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> !ctl.ins_acc)
		else $error("insert taken during drain");
`endif

endmodule

@@ verif/top_k_score_selector_tb.sv @@
// Testbench for top_k_score_selector: directed and random inserts and drains,
// every result checked against a ranked-list predictor kept in a small class.
// Depends on tks_pkg, the tks_ifs channel interfaces and the RTL under src.
`timescale 1ns / 1ps

module top_k_score_selector_tb;

	localparam int SLOTS       = 16;    // MAX_KEEP of the instance
	localparam int QUIET_LIMIT = 3000;  // cycles with no handshake at all
	localparam int LONG_HOLD   = 150;   // receiver hold-off for backpressure
	localparam int SETTLE      = 4;     // extra cycles after the last result
	localparam int RAND_PHASES = 10;

	// one drain result as the block should present it
	typedef struct packed {
		logic [tks_pkg::DATA_W-1:0] eref;
		logic [tks_pkg::DATA_W-1:0] escore;
		logic                       vld;
		logic                       last;
	} drain_word_t;

	// Predicted ranked list plus the queue of drain results still owed.
	class topk_board;
		logic [tks_pkg::DATA_W-1:0] held_ref[SLOTS];
		logic [tks_pkg::DATA_W-1:0] held_score[SLOTS];
		int unsigned                held_cnt;
		logic [tks_pkg::KEEP_W-1:0] keep;
		drain_word_t                expected_words[$];
		int unsigned                fails;

		function new();
			held_cnt = 0;
			keep = tks_pkg::KEEP_RST;
			fails = 0;
		endfunction

		task report(string msg);
			fails++;
			if (fails <= 100)
				$display("MISMATCH: %s", msg);
		endtask

		function void set_keep(logic [tks_pkg::KEEP_W-1:0] k);
			keep = k;
		endfunction

		// keep_count with 0 read as 1 and anything past the row size clamped
		function int unsigned keep_limit();
			if (keep == 0)
				return 1;
			if (keep > SLOTS)
				return SLOTS;
			return int'(keep);
		endfunction

		function void insert_candidate(logic [tks_pkg::DATA_W-1:0] r,
		                               logic [tks_pkg::DATA_W-1:0] s);
			int unsigned lim;
			int unsigned cnt;
			int unsigned pos;
			lim = keep_limit();
			// a lowered limit trims the tail on the next insert
			if (held_cnt > lim)
				held_cnt = lim;
			cnt = held_cnt;
			for (int j = 0; j < cnt; j++)
				if (held_ref[j] == r)
					return;
			// strictly lower score is displaced; ties keep arrival order
			pos = cnt;
			for (int j = 0; j < cnt; j++) begin
				if (held_score[j] < s) begin
					pos = j;
					break;
				end
			end
			if (cnt >= lim) begin
				if (pos >= cnt)
					return;
				cnt = lim - 1;
			end
			for (int j = cnt; j > pos; j--) begin
				held_ref[j] = held_ref[j-1];
				held_score[j] = held_score[j-1];
			end
			held_ref[pos] = r;
			held_score[pos] = s;
			held_cnt = cnt + 1;
		endfunction

		function void drain_list();
			drain_word_t w;
			int unsigned n;
			n = (held_cnt > SLOTS) ? SLOTS : held_cnt;
			if (n == 0) begin
				w = '{eref: '0, escore: '0, vld: 1'b0, last: 1'b1};
				expected_words = {expected_words, w};
			end
			for (int k = 0; k < n; k++) begin
				w = '{eref: held_ref[k], escore: held_score[k], vld: 1'b1,
				      last: (k + 1 == n)};
				expected_words = {expected_words, w};
			end
			held_cnt = 0;
		endfunction

		function void note_item(logic op, logic [tks_pkg::DATA_W-1:0] r,
		                        logic [tks_pkg::DATA_W-1:0] s);
			if (op == tks_pkg::OP_INSERT)
				insert_candidate(r, s);
			else
				drain_list();
		endfunction

		task check_result(logic [tks_pkg::DATA_W-1:0] r, logic [tks_pkg::DATA_W-1:0] s,
		                  logic v, logic l);
			drain_word_t w;
			if (expected_words.size() == 0) begin
				report($sformatf("result with none pending: ref %h score %h", r, s));
				return;
			end
			w = expected_words.pop_front();
			if (r !== w.eref)
				report($sformatf("out_ref got %h want %h", r, w.eref));
			if (s !== w.escore)
				report($sformatf("out_score got %h want %h", s, w.escore));
			if (v !== w.vld)
				report($sformatf("out_valid got %b want %b", v, w.vld));
			if (l !== w.last)
				report($sformatf("out_last got %b want %b", l, w.last));
		endtask
	endclass

	logic clk;
	logic arst_n;

	tks_in_if  in_ch ();
	tks_out_if out_ch ();
	tks_cfg_if cfg_ch ();

	top_k_score_selector #(
		.MAX_KEEP(SLOTS)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (in_ch),
		.results (out_ch),
		.cfg     (cfg_ch)
	);

	topk_board   board;
	logic        calm;       // no random gaps on either side
	logic        hold_req;   // ask the receiver for one long hold-off
	int unsigned hold_left;
	int unsigned quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Receiver: ready changes on the falling edge. A hold request is
	// counted down here so the sender keeps pushing meanwhile.
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ch.ready = 1'b0;
		end else if (!calm && $urandom_range(99) < 7) begin
			out_ch.ready = 1'b0;
		end else begin
			out_ch.ready = 1'b1;
		end
	end

	// Monitor: everything is sampled on the rising edge, before the block's
	// registers move. Also the watchdog for a stuck handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				board.set_keep(cfg_ch.keep_count);
			if (in_ch.valid && in_ch.ready)
				board.note_item(in_ch.op, in_ch.item_ref, in_ch.item_score);
			if (out_ch.valid && out_ch.ready)
				board.check_result(out_ch.out_ref, out_ch.out_score,
				                   out_ch.out_valid, out_ch.out_last);
			if ((cfg_ch.valid && cfg_ch.ready) || (in_ch.valid && in_ch.ready) ||
			    (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// Offer one item; returns on the rising edge where it was taken, with
	// valid still high so a following item can go out without a bubble.
	task automatic send_item(input logic op, input logic [tks_pkg::DATA_W-1:0] r,
	                         input logic [tks_pkg::DATA_W-1:0] s);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 7) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.op = op;
		in_ch.item_ref = r;
		in_ch.item_score = s;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Stop offering, wait for every owed result, then give a trailing
	// insert time to land before anything touches the register.
	task automatic settle();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (board.expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_keep(input logic [tks_pkg::KEEP_W-1:0] k);
		settle();
		@(negedge clk);
		cfg_ch.valid = 1'b1;
		cfg_ch.keep_count = k;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		@(negedge clk);
		cfg_ch.valid = 1'b0;
	endtask

	// Random insert: refs mostly from a small pool so duplicates show up,
	// scores often tiny so ties are common, sometimes at the extremes.
	task automatic send_random_insert();
		logic [tks_pkg::DATA_W-1:0] r;
		logic [tks_pkg::DATA_W-1:0] s;
		int unsigned                pick;
		r = ($urandom_range(99) < 60) ? tks_pkg::DATA_W'($urandom_range(23)) : $urandom();
		pick = $urandom_range(99);
		if (pick < 40)
			s = tks_pkg::DATA_W'($urandom_range(7));
		else if (pick < 45)
			s = '0;
		else if (pick < 50)
			s = '1;
		else
			s = $urandom();
		send_item(tks_pkg::OP_INSERT, r, s);
	endtask

	initial begin
		int unsigned n_items;
		logic [tks_pkg::KEEP_W-1:0] k;

		board = new();
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		quiet = 0;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.op = tks_pkg::OP_INSERT;
		in_ch.item_ref = '0;
		in_ch.item_score = '0;
		out_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.keep_count = tks_pkg::KEEP_RST;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// --- directed, default keep_count of 16 ---
		// empty list: one result, out_valid low, out_last high
		send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
		// extremes, ties (later arrival after equal scores), duplicate ref
		send_item(tks_pkg::OP_INSERT, '0, '0);
		send_item(tks_pkg::OP_INSERT, '1, '1);
		send_item(tks_pkg::OP_INSERT, 32'd5, 32'd100);
		send_item(tks_pkg::OP_INSERT, 32'd6, 32'd100);
		send_item(tks_pkg::OP_INSERT, 32'd7, 32'd100);
		send_item(tks_pkg::OP_INSERT, 32'd5, 32'd999);
		send_item(tks_pkg::OP_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
		send_item(tks_pkg::OP_DRAIN, '0, '0);
		send_item(tks_pkg::OP_DRAIN, '1, '1);

		// keep only one: a weaker candidate drops, a stronger one replaces
		write_keep(tks_pkg::KEEP_W'(1));
		send_item(tks_pkg::OP_INSERT, 32'd10, 32'd50);
		send_item(tks_pkg::OP_INSERT, 32'd11, 32'd10);
		send_item(tks_pkg::OP_INSERT, 32'd12, 32'd60);
		send_item(tks_pkg::OP_INSERT, 32'd12, 32'd70);
		send_item(tks_pkg::OP_DRAIN, '0, '0);

		// limit lowered below the fill: a drain still emits everything held
		write_keep(tks_pkg::KEEP_W'(16));
		send_item(tks_pkg::OP_INSERT, 32'd20, 32'd40);
		send_item(tks_pkg::OP_INSERT, 32'd21, 32'd30);
		send_item(tks_pkg::OP_INSERT, 32'd22, 32'd20);
		send_item(tks_pkg::OP_INSERT, 32'd23, 32'd10);
		write_keep(tks_pkg::KEEP_W'(2));
		send_item(tks_pkg::OP_DRAIN, '0, '0);

		// ...and the next insert trims the tail before it goes in
		write_keep(tks_pkg::KEEP_W'(16));
		send_item(tks_pkg::OP_INSERT, 32'd30, 32'd9);
		send_item(tks_pkg::OP_INSERT, 32'd31, 32'd7);
		send_item(tks_pkg::OP_INSERT, 32'd32, 32'd5);
		write_keep(tks_pkg::KEEP_W'(2));
		send_item(tks_pkg::OP_INSERT, 32'd33, 32'd8);
		send_item(tks_pkg::OP_DRAIN, '0, '0);

		// --- random phases, each with its own keep_count ---
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0)
				k = tks_pkg::KEEP_W'(16);
			else if (ph == 1)
				k = tks_pkg::KEEP_W'(1);
			else
				k = tks_pkg::KEEP_W'($urandom_range(1, 16));
			write_keep(k);
			calm = (ph == 3);
			if (ph == 5) begin
				// receiver holds off while a drain sits in the row: the
				// input must stall behind it and resume afterwards
				hold_req = 1'b1;
				for (int i = 0; i < 10; i++)
					send_random_insert();
				send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
				for (int i = 0; i < 6; i++)
					send_random_insert();
				send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
			end else begin
				n_items = $urandom_range(8, 16);
				for (int i = 0; i < n_items; i++) begin
					if ($urandom_range(99) < 12)
						send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
					else
						send_random_insert();
				end
				// half the phases leave entries behind for the next limit
				if ($urandom_range(1))
					send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
			end
			calm = 1'b0;
		end

		// flush whatever is still held so the final list is checked too
		send_item(tks_pkg::OP_DRAIN, $urandom(), $urandom());
		settle();

		if (board.fails == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ top_k_score_selector.f @@
src/tks_pkg.sv
src/tks_ifs.sv
src/tks_cell.sv
src/top_k_score_selector.sv
verif/top_k_score_selector_tb.sv
